>>> rtl/core/lcfbs_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the stuffing classifier for the led frame stuffer
// no dependencies

package lcfbs_pkg;

    localparam int MAX_LEDS_DEF = 128;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [7:0] START_BYTE = 8'h42;
    localparam logic [7:0] ESC_BYTE   = 8'h65;

    // escape codes; the code itself is the byte sent after the escape
    typedef logic [2:0] t_esc_code;
    localparam t_esc_code ESC_NONE = 3'd0;
    localparam t_esc_code ESC_23   = 3'd1;
    localparam t_esc_code ESC_42   = 3'd2;
    localparam t_esc_code ESC_65   = 3'd3;
    localparam t_esc_code ESC_66   = 3'd4;

    typedef struct packed {
        logic [7:0] num;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        t_esc_code  num_code;
        t_esc_code  red_code;
        t_esc_code  green_code;
        t_esc_code  blue_code;
    } t_record;

    function automatic t_esc_code stuff_code(input logic [7:0] b);
        t_esc_code c;
        case (b)
            8'h23:   c = ESC_23;
            8'h42:   c = ESC_42;
            8'h65:   c = ESC_65;
            8'h66:   c = ESC_66;
            default: c = ESC_NONE;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/core/lcfbs_front.sv
`timescale 1ns / 1ps
// front end: numbers leds within a frame, drops overflow leds, classifies bytes
// depends on lcfbs_pkg

module lcfbs_front #(
    parameter int MAX_LEDS = lcfbs_pkg::MAX_LEDS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_frame_start,
    input  logic [7:0]         i_red,
    input  logic [7:0]         i_green,
    input  logic [7:0]         i_blue,
    input  logic               i_full,
    output logic               o_push,
    output lcfbs_pkg::t_record o_record
);

    logic [7:0] r_led_number;
    logic [7:0] n_led_number;
    logic       accept;
    logic       keep;

    assign accept = i_valid && !i_full;
    // past the limit only a frame start gets through
    assign keep   = i_frame_start || (r_led_number < 8'(MAX_LEDS));
    assign o_push = accept && keep;

    always_comb begin
        n_led_number = r_led_number;
        if (o_push) begin
            n_led_number = i_frame_start ? 8'd1 : r_led_number + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_number <= 8'd0;
        end else begin
            r_led_number <= n_led_number;
        end
    end

    always_comb begin
        o_record.num        = n_led_number;
        o_record.red        = i_red;
        o_record.green      = i_green;
        o_record.blue       = i_blue;
        o_record.num_code   = lcfbs_pkg::stuff_code(n_led_number);
        o_record.red_code   = lcfbs_pkg::stuff_code(i_red);
        o_record.green_code = lcfbs_pkg::stuff_code(i_green);
        o_record.blue_code  = lcfbs_pkg::stuff_code(i_blue);
    end

endmodule

>>> rtl/core/lcfbs_queue.sv
`timescale 1ns / 1ps
// short record queue between front end and serializer
// depends on lcfbs_pkg

module lcfbs_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  lcfbs_pkg::t_record i_record,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_valid,
    output lcfbs_pkg::t_record o_record
);

    localparam int DEPTH = lcfbs_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lcfbs_pkg::t_record r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;

    assign o_full   = (r_count == CNT_W'(DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_record = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_record;
        end
    end

endmodule

>>> rtl/core/lcfbs_serializer.sv
`timescale 1ns / 1ps
// back end: walks one record and sends start byte plus stuffed fields, one word a cycle while not stalled
// depends on lcfbs_pkg

module lcfbs_serializer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  lcfbs_pkg::t_record i_record,
    output logic               o_pop,
    input  logic               i_stall,
    output logic               o_valid,
    output logic [7:0]         o_tx_byte,
    output logic               o_record_end
);

    typedef enum logic [4:0] {
        SL_START = 5'b00001,
        SL_NUM   = 5'b00010,
        SL_RED   = 5'b00100,
        SL_GREEN = 5'b01000,
        SL_BLUE  = 5'b10000
    } t_slot;

    t_slot      r_slot;
    t_slot      n_slot;
    logic       r_second;
    logic       n_second;
    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;
    logic [7:0] n_byte;
    logic       r_end;
    logic       n_end;

    logic                 load;
    logic [7:0]           fld_byte;
    lcfbs_pkg::t_esc_code fld_code;

    // output register frees up when empty or taken this cycle
    assign load = i_q_valid && (!r_valid || !i_stall);

    always_comb begin
        case (r_slot)
            SL_NUM: begin
                fld_byte = i_record.num;
                fld_code = i_record.num_code;
            end
            SL_RED: begin
                fld_byte = i_record.red;
                fld_code = i_record.red_code;
            end
            SL_GREEN: begin
                fld_byte = i_record.green;
                fld_code = i_record.green_code;
            end
            SL_BLUE: begin
                fld_byte = i_record.blue;
                fld_code = i_record.blue_code;
            end
            default: begin
                fld_byte = lcfbs_pkg::START_BYTE;
                fld_code = lcfbs_pkg::ESC_NONE;
            end
        endcase
    end

    always_comb begin
        n_slot   = r_slot;
        n_second = r_second;
        n_valid  = r_valid;
        n_byte   = r_byte;
        n_end    = r_end;
        o_pop    = 1'b0;
        if (load) begin
            n_valid = 1'b1;
            n_end   = 1'b0;
            if (r_slot == SL_START) begin
                n_byte = lcfbs_pkg::START_BYTE;
                n_slot = SL_NUM;
            end else if (fld_code != lcfbs_pkg::ESC_NONE && !r_second) begin
                n_byte   = lcfbs_pkg::ESC_BYTE;
                n_second = 1'b1;
            end else begin
                n_byte   = r_second ? 8'(fld_code) : fld_byte;
                n_second = 1'b0;
                case (r_slot)
                    SL_NUM:   n_slot = SL_RED;
                    SL_RED:   n_slot = SL_GREEN;
                    SL_GREEN: n_slot = SL_BLUE;
                    default: begin
                        n_slot = SL_START;
                        n_end  = 1'b1;
                        o_pop  = 1'b1;
                    end
                endcase
            end
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot   <= SL_START;
            r_second <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_slot   <= n_slot;
            r_second <= n_second;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_end  <= n_end;
    end

    assign o_valid      = r_valid;
    assign o_tx_byte    = r_byte;
    assign o_record_end = r_end;

endmodule

>>> rtl/core/led_color_frame_byte_stuffer.sv
`timescale 1ns / 1ps
// top level of the led color frame byte stuffer
// depends on lcfbs_pkg, lcfbs_front, lcfbs_queue, lcfbs_serializer
//
// usage:
//   input channel (i_valid / o_stall) takes one led color per word, with
//   i_frame_start marking the first led of a frame. leds are numbered from 1.
//   output channel (o_valid / i_stall) gives one serial byte per word: 0x42,
//   then led number, red, green, blue, each stuffed as 0x65 plus code 1..4
//   for 0x23, 0x42, 0x65, 0x66. o_record_end flags the last byte of a led.
//   leds past MAX_LEDS in a frame are dropped and give no bytes.
// timing:
//   first byte of a led is registered in the record queue, then in the output register.
//   each led gives 5 to 9 output bytes, one byte per cycle from the serializer
//   while not stalled; a two-entry record queue lets the front take leds ahead.
//   o_stall rises only while that queue is full.
// reset (synchronous, active low) empties the queue and output register and
//   clears the led number, so the first led is numbered 1 without a frame start.
// a stalled output word holds; the serializer simply waits.

module led_color_frame_byte_stuffer #(
    parameter int MAX_LEDS = lcfbs_pkg::MAX_LEDS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_frame_start,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_tx_byte,
    output logic       o_record_end
);

    logic               q_full;
    logic               q_push;
    logic               q_pop;
    logic               q_valid;
    lcfbs_pkg::t_record push_rec;
    lcfbs_pkg::t_record head_rec;

    assign o_stall = q_full;

    lcfbs_front #(
        .MAX_LEDS (MAX_LEDS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_frame_start (i_frame_start),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_full        (q_full),
        .o_push        (q_push),
        .o_record      (push_rec)
    );

    lcfbs_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_record (push_rec),
        .i_pop    (q_pop),
        .o_full   (q_full),
        .o_valid  (q_valid),
        .o_record (head_rec)
    );

    lcfbs_serializer u_ser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_record     (head_rec),
        .o_pop        (q_pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_tx_byte    (o_tx_byte),
        .o_record_end (o_record_end)
    );

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("record popped from empty queue");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("record pushed into full queue");

    // an escape prefix never ends a record, so its code always follows
    a_esc_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_tx_byte == lcfbs_pkg::ESC_BYTE) |-> !o_record_end)
        else $error("escape byte ends a record");

    // the word after a record end opens the next record
    a_next_is_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_record_end) |=>
        (!o_valid || o_tx_byte == lcfbs_pkg::START_BYTE))
        else $error("record does not begin with start byte");

endmodule
